[hw/rtl/longest_prefix_match_route_defines.svh]
// assertion macros for the longest prefix match route block
`ifndef LONGEST_PREFIX_MATCH_ROUTE_DEFINES_SVH
`define LONGEST_PREFIX_MATCH_ROUTE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LPMR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define LPMR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/lpmr_pkg.sv]
// shared types, codes and defaults for the longest prefix match route block
package lpmr_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int IFACE_BITS_DEF  = 4;

	localparam int ADDR_W      = 32;
	localparam int INDEX_W     = 4;
	localparam int IFACE_W     = 4;
	// only slots addressable by the index field can ever be written
	localparam int MAX_SLOTS   = 1 << INDEX_W;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [INDEX_W-1:0] entry_index;
		logic               entry_valid;
		logic [ADDR_W-1:0]  entry_dest;
		logic [ADDR_W-1:0]  entry_mask;
		logic [ADDR_W-1:0]  entry_gateway;
		logic [IFACE_W-1:0] entry_iface;
		logic [ADDR_W-1:0]  lookup_addr;
	} lpmr_req_t;

	typedef struct packed {
		logic               hit;
		logic [INDEX_W-1:0] matched_index;
		logic [IFACE_W-1:0] out_iface;
		logic [ADDR_W-1:0]  route_hop;
	} lpmr_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_OUT
	} lpmr_state_t;

endpackage

[hw/rtl/longest_prefix_match_route.sv]
// IPv4 longest prefix match routing table with a sequential table walk
//
// Usage: two valid/stall channels. A request transfer on req either writes one
// table slot (operation write) or looks up an address (operation lookup).
// A write takes effect in the cycle of its transfer and gives no response;
// req_stall stays low for it, so writes can stream one per cycle while the block is idle.
// A lookup walks every stored slot through a single masked comparator, one
// slot per cycle, keeping the numerically largest mask (lowest slot on a tie).
// A lookup occupies the block from its transfer to rsp_valid; req_stall is
// high for that whole time. Slots at index 16 and above cannot be addressed,
// so the walk covers at most 16 slots.
// The response sits in an output register until its transfer on rsp; while
// rsp_stall holds it, the finished lookup waits and req stays stalled.
// Reset (arst_n low) clears every slot's valid bit, drops any lookup in
// progress and empties the output register.
`include "longest_prefix_match_route_defines.svh"

module longest_prefix_match_route #(
	parameter int TABLE_DEPTH = lpmr_pkg::TABLE_DEPTH_DEF,
	parameter int IFACE_BITS  = lpmr_pkg::IFACE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  lpmr_pkg::lpmr_req_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output lpmr_pkg::lpmr_rsp_t rsp
);
	import lpmr_pkg::*;

	localparam int STORE_DEPTH = (TABLE_DEPTH < MAX_SLOTS) ? TABLE_DEPTH : MAX_SLOTS;
	localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(STORE_DEPTH - 1);
	localparam logic [INDEX_W:0]   SLOT_LIM  = (INDEX_W + 1)'(STORE_DEPTH);

	// route storage
	logic [ADDR_W-1:0]     route_dest_mem    [STORE_DEPTH];
	logic [ADDR_W-1:0]     route_mask_mem    [STORE_DEPTH];
	logic [ADDR_W-1:0]     route_gateway_mem [STORE_DEPTH];
	logic [IFACE_BITS-1:0] route_iface_mem   [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] valid_q;

	lpmr_state_t state_q, state_d;
	logic [IDX_W-1:0]  scan_idx_q;
	logic [ADDR_W-1:0] addr_q;

	// read stage
	logic                  cmp_vld_s1;
	logic                  cmp_last_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic                  rd_valid_s1;
	logic [ADDR_W-1:0]     rd_dest_s1;
	logic [ADDR_W-1:0]     rd_mask_s1;
	logic [ADDR_W-1:0]     rd_gw_s1;
	logic [IFACE_BITS-1:0] rd_iface_s1;

	// best match so far
	logic                  found_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [ADDR_W-1:0]     best_mask_q;
	logic [ADDR_W-1:0]     best_gw_q;
	logic [IFACE_BITS-1:0] best_iface_q;

	logic      rsp_valid_q;
	lpmr_rsp_t rsp_q, rsp_d;

	logic req_xfer, wr_en, start, issue, load_rsp, take;
	logic [IFACE_BITS-1:0] wr_iface;
	logic [IFACE_W-1:0]    best_iface_out;

	assign req_xfer = req_valid && !req_stall;
	assign wr_en    = req_xfer && (req.operation == OP_WRITE)
		&& ({1'b0, req.entry_index} < SLOT_LIM);

	// interface number resized to the stored width and back
	for (genvar b = 0; b < IFACE_BITS; b++) begin : g_wr_iface
		if (b < IFACE_W) begin : g_bit
			assign wr_iface[b] = req.entry_iface[b];
		end else begin : g_zero
			assign wr_iface[b] = 1'b0;
		end
	end
	for (genvar b = 0; b < IFACE_W; b++) begin : g_rd_iface
		if (b < IFACE_BITS) begin : g_bit
			assign best_iface_out[b] = best_iface_q[b];
		end else begin : g_zero
			assign best_iface_out[b] = 1'b0;
		end
	end

	// sequencer next state and controls
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		start     = 1'b0;
		issue     = 1'b0;
		load_rsp  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid && req.operation == OP_LOOKUP) begin
					start   = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				issue = 1'b1;
				if (scan_idx_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// slot writes: fields of a cleared slot are never used, only its valid bit drops
	always_ff @(posedge clk) begin
		if (wr_en && req.entry_valid) begin
			route_dest_mem[req.entry_index[IDX_W-1:0]]    <= req.entry_dest;
			route_mask_mem[req.entry_index[IDX_W-1:0]]    <= req.entry_mask;
			route_gateway_mem[req.entry_index[IDX_W-1:0]] <= req.entry_gateway;
			route_iface_mem[req.entry_index[IDX_W-1:0]]   <= wr_iface;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[req.entry_index[IDX_W-1:0]] <= req.entry_valid;
		end
	end

	// scan counter and captured lookup address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
		end else if (start) begin
			scan_idx_q <= '0;
		end else if (issue && scan_idx_q != LAST_IDX) begin
			scan_idx_q <= scan_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			addr_q <= req.lookup_addr;
		end
	end

	// registered table read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1  <= 1'b0;
			cmp_last_s1 <= 1'b0;
		end else begin
			cmp_vld_s1  <= issue;
			cmp_last_s1 <= issue && (scan_idx_q == LAST_IDX);
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_idx_s1   <= scan_idx_q;
			rd_valid_s1 <= valid_q[scan_idx_q];
			rd_dest_s1  <= route_dest_mem[scan_idx_q];
			rd_mask_s1  <= route_mask_mem[scan_idx_q];
			rd_gw_s1    <= route_gateway_mem[scan_idx_q];
			rd_iface_s1 <= route_iface_mem[scan_idx_q];
		end
	end

	// shared masked comparator: match, then strictly larger mask value wins
	assign take = cmp_vld_s1 && rd_valid_s1
		&& ((addr_q & rd_mask_s1) == (rd_dest_s1 & rd_mask_s1))
		&& (!found_q || (best_mask_q < rd_mask_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (start) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q   <= rd_idx_s1;
			best_mask_q  <= rd_mask_s1;
			best_gw_q    <= rd_gw_s1;
			best_iface_q <= rd_iface_s1;
		end
	end

	// response build
	always_comb begin
		rsp_d = '0;
		if (found_q) begin
			rsp_d.hit           = 1'b1;
			rsp_d.matched_index = INDEX_W'(best_idx_q);
			rsp_d.out_iface     = best_iface_out;
			rsp_d.route_hop     = (best_gw_q != '0) ? best_gw_q : addr_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	`LPMR_ASSERT_NEXT(a_lookup_starts_scan,
		req_valid && !req_stall && req.operation == OP_LOOKUP,
		state_q == ST_SCAN, "lookup transfer did not start a table walk")
	`LPMR_ASSERT_NEXT(a_write_no_response,
		req_valid && !req_stall && req.operation == OP_WRITE && !rsp_valid,
		!rsp_valid, "table write produced a response")
	`LPMR_ASSERT_NOW(a_drain_has_last,
		state_q == ST_DRAIN, cmp_vld_s1 && cmp_last_s1,
		"drain without the last slot in the compare stage")
	`LPMR_ASSERT_NOW(a_best_is_valid,
		found_q && state_q != ST_IDLE, valid_q[best_idx_q],
		"selected route slot is not valid")
	`LPMR_ASSERT_NOW(a_miss_is_zero,
		rsp_valid && !rsp.hit,
		rsp.matched_index == '0 && rsp.out_iface == '0 && rsp.route_hop == '0,
		"miss response carries nonzero fields")

endmodule

[tb/testbench.sv]
// self-checking testbench for the longest prefix match route block
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lpmr_pkg::*;

	localparam int DEPTH       = TABLE_DEPTH_DEF;
	localparam int GAP_MAX     = 18;
	localparam int DRAIN_WAIT  = 25;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_ITEMS = 1330;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	lpmr_req_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	lpmr_rsp_t rsp;

	// shadow copy of the routing table
	logic [ADDR_W-1:0]  tbl_dest [DEPTH];
	logic [ADDR_W-1:0]  tbl_mask [DEPTH];
	logic [ADDR_W-1:0]  tbl_gw   [DEPTH];
	logic [IFACE_W-1:0] tbl_iface[DEPTH];
	logic               tbl_live [DEPTH];

	lpmr_rsp_t route_expect[$];

	bit idling = 1'b1;
	int unsigned cycle_count = 0;
	int unsigned stall_left  = 0;
	int unsigned mismatches  = 0;
	int unsigned write_count = 0;
	int unsigned clear_count = 0;
	int unsigned lookup_count = 0;
	int unsigned hit_count   = 0;

	longest_prefix_match_route u_top (.*);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int unsigned draw_gap();
		return idling ? $urandom_range(0, GAP_MAX) : 0;
	endfunction

	function automatic logic [ADDR_W-1:0] prefix_mask(input int unsigned len);
		return (len == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - len));
	endfunction

	// longest match over the shadow table, lowest slot on equal masks
	function automatic lpmr_rsp_t route_lookup(input logic [ADDR_W-1:0] addr);
		lpmr_rsp_t res;
		int best;
		best = -1;
		res  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (tbl_live[i] && ((addr & tbl_mask[i]) == (tbl_dest[i] & tbl_mask[i])) &&
			    (best < 0 || tbl_mask[best] < tbl_mask[i]))
				best = i;
		end
		if (best >= 0) begin
			res.hit           = 1'b1;
			res.matched_index = INDEX_W'(best);
			res.out_iface     = tbl_iface[best];
			res.route_hop     = (tbl_gw[best] != '0) ? tbl_gw[best] : addr;
		end
		return res;
	endfunction

	function automatic lpmr_req_t make_write(input int unsigned idx, input logic live,
			input logic [ADDR_W-1:0] dest, input logic [ADDR_W-1:0] mask,
			input logic [ADDR_W-1:0] gw, input int unsigned iface);
		lpmr_req_t item;
		item.operation     = OP_WRITE;
		item.entry_index   = INDEX_W'(idx);
		item.entry_valid   = live;
		item.entry_dest    = dest;
		item.entry_mask    = mask;
		item.entry_gateway = gw;
		item.entry_iface   = IFACE_W'(iface);
		item.lookup_addr   = $urandom;
		return item;
	endfunction

	// write fields carry noise, the block must ignore them
	function automatic lpmr_req_t make_lookup(input logic [ADDR_W-1:0] addr);
		lpmr_req_t item;
		item = make_write($urandom_range(0, DEPTH - 1), 1'($urandom_range(0, 1)),
			$urandom, $urandom, $urandom, $urandom_range(0, 15));
		item.operation   = OP_LOOKUP;
		item.lookup_addr = addr;
		return item;
	endfunction

	// update the shadow table or queue the expected route
	task automatic apply_item(input lpmr_req_t item);
		int unsigned slot;
		slot = item.entry_index;
		if (item.operation == OP_WRITE) begin
			if (slot < DEPTH) begin
				tbl_live[slot]  = item.entry_valid;
				tbl_dest[slot]  = item.entry_valid ? item.entry_dest : '0;
				tbl_mask[slot]  = item.entry_valid ? item.entry_mask : '0;
				tbl_gw[slot]    = item.entry_valid ? item.entry_gateway : '0;
				tbl_iface[slot] = item.entry_valid ? item.entry_iface : '0;
			end
			write_count++;
			if (!item.entry_valid)
				clear_count++;
		end else begin
			route_expect.push_back(route_lookup(item.lookup_addr));
			lookup_count++;
		end
	endtask

	// one request transfer, valid held high when no gap is drawn
	task automatic send_item(input lpmr_req_t item);
		int unsigned gap;
		gap = draw_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		apply_item(item);
	endtask

	// response side: random stall per transfer and in-order compare
	always @(posedge clk) begin : rsp_monitor
		lpmr_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (route_expect.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response: hit %0b index %0d iface %0d hop %h",
						rsp.hit, rsp.matched_index, rsp.out_iface, rsp.route_hop);
			end else begin
				want = route_expect.pop_front();
				if (rsp.hit !== want.hit || rsp.matched_index !== want.matched_index ||
				    rsp.out_iface !== want.out_iface || rsp.route_hop !== want.route_hop) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"route mismatch: expected hit %0b index %0d iface %0d",
							" hop %h, got hit %0b index %0d iface %0d hop %h"},
							want.hit, want.matched_index, want.out_iface, want.route_hop,
							rsp.hit, rsp.matched_index, rsp.out_iface, rsp.route_hop);
				end else if (want.hit) begin
					hit_count++;
				end
			end
			stall_left = draw_gap();
		end
		rsp_stall <= (stall_left > 0);
		if (stall_left > 0 && rsp_valid)
			stall_left--;
	end

	// reset and shadow table clear
	task automatic do_reset();
		for (int i = 0; i < DEPTH; i++) begin
			tbl_live[i]  = 1'b0;
			tbl_dest[i]  = '0;
			tbl_mask[i]  = '0;
			tbl_gw[i]    = '0;
			tbl_iface[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// lookups into a freshly reset table all miss
	task automatic test_empty_table();
		send_item(make_lookup(32'h0000_0000));
		send_item(make_lookup(32'hFFFF_FFFF));
		send_item(make_lookup($urandom));
	endtask

	// hand-picked routes: default, direct, host, tie, odd mask, clearing
	task automatic test_directed_routes();
		send_item(make_write(15, 1'b1, 32'h0000_0000, 32'h0, 32'hC0A8_0001, 1));
		send_item(make_lookup(32'h0808_0808));
		send_item(make_write(3, 1'b1, 32'h0A00_0000, prefix_mask(8), 32'h0, 0));
		send_item(make_lookup(32'h0A12_3456));
		send_item(make_write(7, 1'b1, 32'h0A01_0200, prefix_mask(24), 32'hFFFF_FFFF, 15));
		send_item(make_lookup(32'h0A01_02FF));
		send_item(make_write(0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 15));
		send_item(make_lookup(32'hFFFF_FFFF));
		// two routes on the same network with the same mask
		send_item(make_write(2, 1'b1, 32'hAC10_0000, prefix_mask(12), 32'h0000_0001, 2));
		send_item(make_write(5, 1'b1, 32'hAC1F_0000, prefix_mask(12), 32'h0000_0002, 5));
		send_item(make_lookup(32'hAC1A_BCDE));
		// non-contiguous mask numerically above the /24
		send_item(make_write(9, 1'b1, 32'h0A01_0205, 32'hFFFF_FF0F, 32'h0000_0003, 9));
		send_item(make_lookup(32'h0A01_02F5));
		send_item(make_write(9, 1'b0, $urandom, $urandom, $urandom, 6));
		send_item(make_lookup(32'h0A01_02F5));
		send_item(make_write(15, 1'b0, $urandom, $urandom, $urandom, 3));
		send_item(make_lookup(32'h0808_0808));
		send_item(make_lookup(32'h0000_0000));
	endtask

	// random table churn with lookups aimed mostly at installed routes
	task automatic test_random_traffic();
		logic [ADDR_W-1:0] net_pool[4];
		logic [ADDR_W-1:0] dest, mask, gw, addr;
		int unsigned slot;
		for (int i = 0; i < 4; i++)
			net_pool[i] = $urandom & prefix_mask(8);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0)
				idling = ($urandom_range(0, 2) != 0);
			if ($urandom_range(0, 99) < 35) begin
				mask = ($urandom_range(0, 7) == 0) ? $urandom : prefix_mask($urandom_range(0, 32));
				if ($urandom_range(0, 1))
					dest = net_pool[$urandom_range(0, 3)] |
						($urandom & ~prefix_mask($urandom_range(8, 16)));
				else
					dest = $urandom;
				gw = ($urandom_range(0, 2) == 0) ? '0 : $urandom;
				send_item(make_write($urandom_range(0, DEPTH - 1), $urandom_range(0, 9) != 0,
					dest, mask, gw, $urandom_range(0, 15)));
			end else begin
				slot = $urandom_range(0, DEPTH - 1);
				case ($urandom_range(0, 19))
					0: addr = 32'h0000_0000;
					1: addr = 32'hFFFF_FFFF;
					2, 3, 4: addr = $urandom;
					default: begin
						addr = (tbl_dest[slot] & tbl_mask[slot]) | ($urandom & ~tbl_mask[slot]);
					end
				endcase
				send_item(make_lookup(addr));
			end
		end
		idling = 1'b1;
	endtask

	// test sequence
	initial begin
		do_reset();
		test_empty_table();
		test_directed_routes();
		test_random_traffic();
		req_valid <= 1'b0;
		while (route_expect.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d table writes (%0d clearing) and %0d lookups, %0d routed",
			write_count, clear_count, lookup_count, hit_count);
		if (mismatches == 0 && route_expect.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
